@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with clocking and reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RRCA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// Expression must never be true outside reset.
`define RRCA_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

@@ rtl/rrca_pkg.sv @@
// ----------------------------------------------------------------------------
// rrca_pkg
// Shared types and constants of the round-robin channel averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrca_pkg;

    localparam int RRCA_NUM_CHANNELS = 5;
    localparam int MAX_SAMPLES       = 1024;
    localparam int SAMPLE_BITS       = 12;
    localparam int AVG_FIELDS        = 5;
    localparam int CMD_W             = 2;
    localparam int FCH_W             = 3;
    // count register and effective count (holds MAX_SAMPLES itself)
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    // per-channel sample counter, always below MAX_SAMPLES between transfers
    localparam int SCNT_W = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SAMPLE_BITS + SCNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_FETCH   = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef struct packed {
        logic                   fetch_ok;
        logic [SAMPLE_BITS-1:0] avg_ch0;
        logic [SAMPLE_BITS-1:0] avg_ch1;
        logic [SAMPLE_BITS-1:0] avg_ch2;
        logic [SAMPLE_BITS-1:0] avg_ch3;
        logic [SAMPLE_BITS-1:0] avg_ch4;
        logic                   channel_finished;
        logic [FCH_W-1:0]       finished_channel;
        logic                   scan_complete;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ rtl/rrca_in_if.sv @@
// ----------------------------------------------------------------------------
// rrca_in_if
// Command/sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrca_in_if import rrca_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [SAMPLE_BITS-1:0] sample_mv;

    modport source (output valid, output command, output sample_mv, input ready);
    modport sink   (input valid, input command, input sample_mv, output ready);
endinterface

`default_nettype wire

@@ rtl/rrca_out_if.sv @@
// ----------------------------------------------------------------------------
// rrca_out_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrca_out_if import rrca_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   fetch_ok;
    logic [SAMPLE_BITS-1:0] avg_ch0;
    logic [SAMPLE_BITS-1:0] avg_ch1;
    logic [SAMPLE_BITS-1:0] avg_ch2;
    logic [SAMPLE_BITS-1:0] avg_ch3;
    logic [SAMPLE_BITS-1:0] avg_ch4;
    logic                   channel_finished;
    logic [FCH_W-1:0]       finished_channel;
    logic                   scan_complete;

    modport source (
        output valid, output fetch_ok, output avg_ch0, output avg_ch1,
        output avg_ch2, output avg_ch3, output avg_ch4, output channel_finished,
        output finished_channel, output scan_complete, input ready
    );
    modport sink (
        input valid, input fetch_ok, input avg_ch0, input avg_ch1,
        input avg_ch2, input avg_ch3, input avg_ch4, input channel_finished,
        input finished_channel, input scan_complete, output ready
    );
endinterface

`default_nettype wire

@@ rtl/round_robin_channel_averager.sv @@
// ----------------------------------------------------------------------------
// round_robin_channel_averager
// Per-channel sample accumulation over a round-robin scan with block averages.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries command (tick, fetch, restart) and sample_mv; o_out carries
//   one result per input transfer. i_cfg_we/i_cfg_data set samples per channel
//   (zero acts as one, values above the maximum clamp); write only when idle.
//   A tick adds the sample to the current channel's sum. When the count is
//   reached the sum is divided by the count in a bit-serial divider (one
//   quotient bit per cycle) and stored as that channel's average. An
//   accepted transfer's result is held in a pending register and moved to the
//   output register from the put state; a tick that closes a channel average
//   first waits in the divide state for the quotient. One item is in flight at
//   a time, so the next input transfer follows once the result is handed to
//   the output register.
//   A stalled receiver holds the result in the output register; one more item
//   is processed and then waits until the register frees up.
//   Reset (synchronous, active low) clears all sums, averages, the channel
//   pointer and the scan-ready flag, and sets samples per channel to one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module round_robin_channel_averager import rrca_pkg::*; #(
    parameter int NUM_CHANNELS = RRCA_NUM_CHANNELS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    rrca_in_if.sink               i_in,
    rrca_out_if.source            o_out
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUT
    } t_state;

    t_state                 r_state;
    logic [SUM_W-1:0]       r_sum [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] r_avg [NUM_CHANNELS];
    logic [CH_W-1:0]        r_ch;
    logic [CH_W-1:0]        r_div_ch;
    logic [SCNT_W-1:0]      r_cnt;
    logic                   r_scan_ready;
    logic [CNT_W-1:0]       r_n;
    t_result                r_pend;
    t_result                n_pend;
    t_result                r_out;
    logic                   r_out_valid;

    logic                   w_accept;
    logic [CNT_W-1:0]       w_cnt_inc;
    logic [SUM_W-1:0]       w_sum_new;
    logic                   w_finish;
    logic [CH_W-1:0]        w_ch_next;
    logic [CH_W+FCH_W-1:0]  w_ch_ext;
    logic [AVG_FIELDS-1:0][SAMPLE_BITS-1:0] w_fetch;
    t_div_req               w_div_req;
    t_div_rsp               w_div_rsp;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] val);
        logic [CNT_W-1:0] res;
        res = val;
        if (val == '0) begin
            res = CNT_W'(1);
        end else if (val > CNT_W'(MAX_SAMPLES)) begin
            res = CNT_W'(MAX_SAMPLES);
        end
        return res;
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_sum_new = r_sum[r_ch] + SUM_W'(i_in.sample_mv);
    assign w_finish  = (w_cnt_inc >= r_n);
    assign w_ch_next = (r_ch == LAST_CH) ? '0 : r_ch + 1'b1;
    assign w_ch_ext  = {{FCH_W{1'b0}}, r_ch};

    for (genvar g = 0; g < AVG_FIELDS; g++) begin : g_fetch
        if (g < NUM_CHANNELS) begin : g_on
            assign w_fetch[g] = r_avg[g];
        end else begin : g_off
            assign w_fetch[g] = '0;
        end
    end

    assign w_div_req.start    = w_accept && (t_cmd'(i_in.command) == CMD_TICK) && w_finish;
    assign w_div_req.dividend = w_sum_new;
    assign w_div_req.divisor  = r_n;

    rrca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // result fields of the command on the input channel
    always_comb begin
        n_pend = '0;
        unique case (t_cmd'(i_in.command))
            CMD_TICK: begin
                n_pend.finished_channel = w_ch_ext[FCH_W-1:0];
                if (w_finish) begin
                    n_pend.channel_finished = 1'b1;
                    n_pend.scan_complete    = (r_ch == LAST_CH);
                end
            end
            CMD_FETCH: begin
                if (r_scan_ready) begin
                    n_pend.fetch_ok = 1'b1;
                    n_pend.avg_ch0  = w_fetch[0];
                    n_pend.avg_ch1  = w_fetch[1];
                    n_pend.avg_ch2  = w_fetch[2];
                    n_pend.avg_ch3  = w_fetch[3];
                    n_pend.avg_ch4  = w_fetch[4];
                end
            end
            default: begin
                // restart and unused command code: all-zero result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ch         <= '0;
            r_cnt        <= '0;
            r_scan_ready <= 1'b0;
            r_n          <= CNT_W'(1);
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i] <= '0;
                r_avg[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_n <= eff_count(i_cfg_data);
            end
            if (o_out.ready && (r_state != S_PUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pend  <= n_pend;
                        r_state <= w_div_req.start ? S_DIV : S_PUT;
                        unique case (t_cmd'(i_in.command))
                            CMD_TICK: begin
                                if (w_finish) begin
                                    r_sum[r_ch] <= '0;
                                    r_cnt       <= '0;
                                    r_div_ch    <= r_ch;
                                    r_ch        <= w_ch_next;
                                    if (r_ch == LAST_CH) begin
                                        r_scan_ready <= 1'b1;
                                    end
                                end else begin
                                    r_sum[r_ch] <= w_sum_new;
                                    r_cnt       <= w_cnt_inc[SCNT_W-1:0];
                                end
                            end
                            CMD_FETCH: begin
                                if (r_scan_ready) begin
                                    r_scan_ready <= 1'b0;
                                end
                            end
                            CMD_RESTART: begin
                                r_ch         <= '0;
                                r_cnt        <= '0;
                                r_scan_ready <= 1'b0;
                                for (int i = 0; i < NUM_CHANNELS; i++) begin
                                    r_sum[i] <= '0;
                                    r_avg[i] <= '0;
                                end
                            end
                            default: begin
                                // unused command code: nothing changes
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_avg[r_div_ch] <= w_div_rsp.quotient;
                        r_state         <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.fetch_ok         = r_out.fetch_ok;
    assign o_out.avg_ch0          = r_out.avg_ch0;
    assign o_out.avg_ch1          = r_out.avg_ch1;
    assign o_out.avg_ch2          = r_out.avg_ch2;
    assign o_out.avg_ch3          = r_out.avg_ch3;
    assign o_out.avg_ch4          = r_out.avg_ch4;
    assign o_out.channel_finished = r_out.channel_finished;
    assign o_out.finished_channel = r_out.finished_channel;
    assign o_out.scan_complete    = r_out.scan_complete;

endmodule

`default_nettype wire

@@ rtl/rrca_div.sv @@
// ----------------------------------------------------------------------------
// rrca_div
// Bit-serial restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrca_div import rrca_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;    // dividend shifts out the top, quotient in the bottom
    logic [CNT_W-1:0]  r_den;

    logic [CNT_W:0]    w_shift;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = (|r_quo[SUM_W-1:SAMPLE_BITS]) ? {SAMPLE_BITS{1'b1}}
                                                          : r_quo[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/rrca_checker.sv @@
// ----------------------------------------------------------------------------
// rrca_checker
// Port-level checks on the result channel of the channel averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rrca_checker import rrca_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic                   i_ready,
    input  wire logic                   i_fetch_ok,
    input  wire logic [SAMPLE_BITS-1:0] i_avg_ch0,
    input  wire logic [SAMPLE_BITS-1:0] i_avg_ch1,
    input  wire logic [SAMPLE_BITS-1:0] i_avg_ch2,
    input  wire logic [SAMPLE_BITS-1:0] i_avg_ch3,
    input  wire logic [SAMPLE_BITS-1:0] i_avg_ch4,
    input  wire logic                   i_channel_finished,
    input  wire logic [FCH_W-1:0]       i_finished_channel,
    input  wire logic                   i_scan_complete
);

    logic w_avg_any;
    assign w_avg_any = (|i_avg_ch0) || (|i_avg_ch1) || (|i_avg_ch2) ||
                       (|i_avg_ch3) || (|i_avg_ch4);

    // a fetch result never carries tick status
    `RRCA_NEVER(a_fetch_no_tick, i_clk, i_rst_n, i_valid && i_fetch_ok && (i_channel_finished || i_scan_complete || (|i_finished_channel)))

    // scan completion only together with a finished channel
    `RRCA_ASSERT(a_scan_needs_finish, i_clk, i_rst_n, (i_valid && i_scan_complete) |-> i_channel_finished)

    // averages only show on a successful fetch
    `RRCA_NEVER(a_avg_only_on_fetch, i_clk, i_rst_n, i_valid && !i_fetch_ok && w_avg_any)

    // a stalled result holds
    `RRCA_ASSERT(a_stall_holds, i_clk, i_rst_n, (i_valid && !i_ready) |=> (i_valid && $stable(i_fetch_ok) && $stable(i_channel_finished) && $stable(i_finished_channel) && $stable(i_scan_complete)))

endmodule

bind round_robin_channel_averager rrca_checker u_rrca_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (o_out.valid),
    .i_ready            (o_out.ready),
    .i_fetch_ok         (o_out.fetch_ok),
    .i_avg_ch0          (o_out.avg_ch0),
    .i_avg_ch1          (o_out.avg_ch1),
    .i_avg_ch2          (o_out.avg_ch2),
    .i_avg_ch3          (o_out.avg_ch3),
    .i_avg_ch4          (o_out.avg_ch4),
    .i_channel_finished (o_out.channel_finished),
    .i_finished_channel (o_out.finished_channel),
    .i_scan_complete    (o_out.scan_complete)
);

`default_nettype wire

@@ sim/rrca_scan_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrca_scan_checker
// Watches the command and result channels of the round-robin averager and
// the count register writes. It keeps its own copy of the per-channel sums,
// averages and scan pointer. Each accepted command yields one predicted
// result, and each result transfer is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module rrca_scan_checker import rrca_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    rrca_in_if               i_in,
    rrca_out_if              i_out,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int SMAX = (1 << SAMPLE_BITS) - 1;

    logic [SUM_W-1:0]       chan_sum [RRCA_NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] chan_avg [RRCA_NUM_CHANNELS];
    logic [FCH_W-1:0]       scan_ch;
    logic [SCNT_W-1:0]      sample_cnt;
    logic                   scan_ready;
    logic [CNT_W-1:0]       count_reg;

    t_result scan_results_due[$];
    int      mismatch_count = 0;
    int      results_waiting = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = results_waiting;

    function automatic void clear_scan();
        for (int i = 0; i < RRCA_NUM_CHANNELS; i++) begin
            chan_sum[i] = '0;
            chan_avg[i] = '0;
        end
        scan_ch    = '0;
        sample_cnt = '0;
        scan_ready = 1'b0;
    endfunction

    function automatic t_result advance_scan(input logic [CMD_W-1:0] cmd,
                                             input logic [SAMPLE_BITS-1:0] mv);
        t_result          r;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] cnt_next;
        logic [SUM_W-1:0] quo;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                if (count_reg == '0)
                    n = CNT_W'(1);
                else if (count_reg > CNT_W'(MAX_SAMPLES))
                    n = CNT_W'(MAX_SAMPLES);
                else
                    n = count_reg;
                chan_sum[scan_ch] = chan_sum[scan_ch] + SUM_W'(mv);
                cnt_next = CNT_W'(sample_cnt) + CNT_W'(1);
                r.finished_channel = scan_ch;
                // count may have been lowered below samples already taken
                if (cnt_next >= n) begin
                    quo = chan_sum[scan_ch] / SUM_W'(n);
                    chan_avg[scan_ch] = (quo > SUM_W'(SMAX)) ? SAMPLE_BITS'(SMAX)
                                                             : quo[SAMPLE_BITS-1:0];
                    chan_sum[scan_ch] = '0;
                    sample_cnt = '0;
                    r.channel_finished = 1'b1;
                    if (scan_ch == FCH_W'(RRCA_NUM_CHANNELS - 1)) begin
                        scan_ch = '0;
                        scan_ready = 1'b1;
                        r.scan_complete = 1'b1;
                    end else begin
                        scan_ch = scan_ch + 1'b1;
                    end
                end else begin
                    sample_cnt = cnt_next[SCNT_W-1:0];
                end
            end
            CMD_FETCH: begin
                if (scan_ready) begin
                    scan_ready = 1'b0;
                    r.fetch_ok = 1'b1;
                    r.avg_ch0  = chan_avg[0];
                    r.avg_ch1  = chan_avg[1];
                    r.avg_ch2  = chan_avg[2];
                    r.avg_ch3  = chan_avg[3];
                    r.avg_ch4  = chan_avg[4];
                end
            end
            CMD_RESTART: begin
                clear_scan();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    task automatic compare_results(input t_result want, input t_result seen);
        check_field("fetch_ok", 16'(want.fetch_ok), 16'(seen.fetch_ok));
        check_field("avg_ch0", 16'(want.avg_ch0), 16'(seen.avg_ch0));
        check_field("avg_ch1", 16'(want.avg_ch1), 16'(seen.avg_ch1));
        check_field("avg_ch2", 16'(want.avg_ch2), 16'(seen.avg_ch2));
        check_field("avg_ch3", 16'(want.avg_ch3), 16'(seen.avg_ch3));
        check_field("avg_ch4", 16'(want.avg_ch4), 16'(seen.avg_ch4));
        check_field("channel_finished", 16'(want.channel_finished),
                    16'(seen.channel_finished));
        check_field("finished_channel", 16'(want.finished_channel),
                    16'(seen.finished_channel));
        check_field("scan_complete", 16'(want.scan_complete), 16'(seen.scan_complete));
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        if (!i_rst_n) begin
            count_reg = CNT_W'(1);
            clear_scan();
            scan_results_due.delete();
        end else begin
            if (i_cfg_we)
                count_reg = i_cfg_data;
            // a result transfer always belongs to an earlier command, so pop first
            if (i_out.valid && i_out.ready) begin
                seen.fetch_ok         = i_out.fetch_ok;
                seen.avg_ch0          = i_out.avg_ch0;
                seen.avg_ch1          = i_out.avg_ch1;
                seen.avg_ch2          = i_out.avg_ch2;
                seen.avg_ch3          = i_out.avg_ch3;
                seen.avg_ch4          = i_out.avg_ch4;
                seen.channel_finished = i_out.channel_finished;
                seen.finished_channel = i_out.finished_channel;
                seen.scan_complete    = i_out.scan_complete;
                if (scan_results_due.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    mismatch_count++;
                end else begin
                    compare_results(scan_results_due.pop_front(), seen);
                end
            end
            if (i_in.valid && i_in.ready)
                scan_results_due.push_back(advance_scan(i_in.command, i_in.sample_mv));
        end
        results_waiting = scan_results_due.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands and count writes into the round-robin channel averager
// under random idling on both channels, with a long receiver hold-off and
// a full drain. Prediction and comparison live in rrca_scan_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import rrca_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;
    int               fail_count;
    int               pending_count;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               hold_request = 0;
    int               hold_left = 0;

    rrca_in_if  in_ch ();
    rrca_out_if out_ch ();

    round_robin_channel_averager dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    rrca_scan_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [SAMPLE_BITS-1:0] mv);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.sample_mv <= mv;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int n_items, input bit ticks_only);
        int                     pick;
        logic [CMD_W-1:0]       cmd;
        logic [SAMPLE_BITS-1:0] mv;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (ticks_only || pick < 80)
                cmd = CMD_TICK;
            else if (pick < 94)
                cmd = CMD_FETCH;
            else if (pick < 98)
                cmd = CMD_RESERVED;
            else
                cmd = CMD_RESTART;
            pick = $urandom_range(99);
            if (pick < 8)
                mv = '0;
            else if (pick < 16)
                mv = '1;
            else
                mv = SAMPLE_BITS'($urandom_range(SAMPLE_BITS'('1)));
            send_item(cmd, mv);
        end
    endtask

    // stop offering and wait for every outstanding result transfer
    task automatic await_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic load_count(input logic [CNT_W-1:0] value);
        await_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_TICK;
        in_ch.sample_mv = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one full scan at the reset count, fetches, odd commands
        tx_idle_pct = 28;
        rx_idle_pct = 51;
        send_item(CMD_TICK, '0);
        send_item(CMD_TICK, '1);
        send_item(CMD_TICK, 12'h800);
        send_item(CMD_TICK, 12'd1);
        send_item(CMD_TICK, '1);
        send_item(CMD_FETCH, '0);
        send_item(CMD_FETCH, '1);
        send_item(CMD_RESERVED, '1);
        send_item(CMD_RESTART, '0);
        send_item(CMD_FETCH, '0);
        // zero count acts as one
        load_count('0);
        send_item(CMD_TICK, 12'd123);
        send_item(CMD_TICK, 12'h555);
        // lower the count mid-channel; the finishing average saturates
        load_count(CNT_W'(MAX_SAMPLES));
        send_item(CMD_TICK, '1);
        send_item(CMD_TICK, '1);
        send_item(CMD_TICK, '1);
        load_count(CNT_W'(2));
        send_item(CMD_TICK, '1);
        send_item(CMD_RESTART, 12'hAAA);

        // receiver stalls for a long stretch while transfers keep coming
        await_results();
        hold_request = 200;
        repeat (8) send_item(CMD_TICK, SAMPLE_BITS'($urandom));
        await_results();

        tx_idle_pct = 28;
        rx_idle_pct = 51;
        load_count(CNT_W'(1));
        send_random(100, 1'b0);
        load_count(CNT_W'(3));
        send_random(100, 1'b0);

        tx_idle_pct = 51;
        rx_idle_pct = 28;
        load_count('0);
        send_random(100, 1'b0);
        load_count(CNT_W'(5));
        send_random(100, 1'b0);

        // above-range count clamps; one channel closes after the full count
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_count('1);
        send_random(MAX_SAMPLES + 6, 1'b1);
        load_count(CNT_W'(1));
        send_random(60, 1'b0);

        await_results();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
